@@ design/buddy_page_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define BPA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define BPA_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);
`else
`define BPA_ASSERT(label, expr, msg)
`define BPA_ASSERT_NEXT(label, trig, expr, msg)
`endif
`endif

@@ design/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Widths, codes, page record layout, controller states and status flags.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int RANK_LIMIT = 16;
    localparam int PAGE_SLOTS = 32768;
    localparam int PAGE_W     = 15;
    localparam int RANK_W     = 5;
    localparam int TP_W       = 16;

    localparam logic [RANK_W-1:0] RANK_LIMIT_R = RANK_W'(RANK_LIMIT);

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    // Per-page record: taken flag, link valid flags, rank.
    typedef struct packed {
        logic              taken;
        logic              lv_prev;
        logic              lv_next;
        logic [RANK_W-1:0] rank;
    } page_info_t;

    typedef enum logic [21:0] {
        S_CLEAR  = 22'h000001,
        S_IDLE   = 22'h000002,
        S_DECODE = 22'h000004,
        S_SEARCH = 22'h000008,
        S_SPLIT  = 22'h000010,
        S_TAKE   = 22'h000020,
        S_FCHK   = 22'h000040,
        S_MERGE  = 22'h000080,
        S_MCHK   = 22'h000100,
        S_MUP    = 22'h000200,
        S_QANS   = 22'h000400,
        S_CNT    = 22'h000800,
        S_CNTW   = 22'h001000,
        S_P0     = 22'h002000,
        S_P1     = 22'h004000,
        S_P2     = 22'h008000,
        S_U0     = 22'h010000,
        S_U1     = 22'h020000,
        S_U2     = 22'h040000,
        S_U3     = 22'h080000,
        S_U4     = 22'h100000,
        S_RESULT = 22'h200000
    } state_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic cfg_start;
        op_t  op;
        logic rank_ok;
        logic page_ok;
        logic head_hit;
        logic cur_top;
        logic split_more;
        logic taken;
        logic merge_go;
        logic merge_join;
        logic push_skip;
        logic cnt_go;
        logic clr_last;
    } ctl_status_t;

    // Top rank: bit length of (tp - 1) plus one, capped at the maximum rank.
    function automatic logic [RANK_W-1:0] top_rank(input logic [TP_W-1:0] tp);
        logic [TP_W-1:0]   v;
        logic [RANK_W-1:0] len;
        v   = tp - TP_W'(1);
        len = '0;
        for (int i = 0; i < TP_W; i++) begin
            if (v[i]) begin
                len = RANK_W'(i + 1);
            end
        end
        top_rank = (len >= RANK_LIMIT_R) ? RANK_LIMIT_R : len + RANK_W'(1);
    endfunction

endpackage

@@ design/buddy_page_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates, frees, queries and counts buddy blocks over up to 32768 pages.
//
// Channel  Direction  Beat marked by        Fields
// config   in         cfg_we                cfg_wdata (page count)
// request  in         start && !busy        operation, rank, page_index
// result   out        done (one cycle)      status, block_page, answer
//
// From acceptance to the result strobe a bad argument passes through decode
// and result, a query also through an answer state. Allocate and free are
// made of rank search steps, unlinks (U0-U4) and pushes (P0-P2); a count
// visits CNT and CNTW per listed block. After reset and each nonzero config
// write a clearing pass over 32768 pages, then a push, runs with busy high.
// The done strobe is high for exactly one cycle; a new request may start then.
// ----------------------------------------------------------------------------
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TP_W-1:0]   cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [RANK_W-1:0] rank,
    input  logic [15:0]       page_index,
    output logic              done,
    output logic [1:0]        status,
    output logic [PAGE_W-1:0] block_page,
    output logic [15:0]       answer
);

    state_t      cmd;
    ctl_status_t st;

    // Sequencer.
    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Storage and arithmetic.
    bpa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .operation  (operation),
        .rank       (rank),
        .page_index (page_index),
        .cmd        (cmd),
        .st         (st),
        .status     (status),
        .block_page (block_page),
        .answer     (answer),
        .done       (done)
    );

endmodule

@@ design/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences clearing, request decoding, searches, splits, merges, list walks
// and the shared push and unlink routines.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ctl_status_t st,
    output state_t      cmd,
    output logic        busy
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    assign cmd  = state_reg;
    assign busy = (state_reg != S_IDLE);

    // Next state and return point of the push and unlink routines.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        if (st.cfg_start)
        begin
            state_next = S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (st.clr_last)
                    begin
                        state_next = S_P0;
                        ret_next   = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_next = S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (st.op)
                        OP_ALLOC: state_next = st.rank_ok ? S_SEARCH : S_RESULT;
                        OP_FREE:  state_next = st.page_ok ? S_FCHK : S_RESULT;
                        OP_QUERY: state_next = st.page_ok ? S_QANS : S_RESULT;
                        OP_COUNT: state_next = st.rank_ok ? S_CNT : S_RESULT;
                        default:  state_next = S_RESULT;
                    endcase
                end
                S_SEARCH:
                begin
                    if (st.head_hit)
                    begin
                        state_next = S_U0;
                        ret_next   = S_SPLIT;
                    end
                    else if (st.cur_top)
                    begin
                        state_next = S_RESULT;
                    end
                end
                S_SPLIT:
                begin
                    if (st.split_more)
                    begin
                        state_next = S_P0;
                        ret_next   = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
                S_TAKE:   state_next = S_RESULT;
                S_FCHK:   state_next = st.taken ? S_MERGE : S_RESULT;
                S_MERGE:
                begin
                    if (st.merge_go)
                    begin
                        state_next = S_MCHK;
                    end
                    else
                    begin
                        state_next = S_P0;
                        ret_next   = S_RESULT;
                    end
                end
                S_MCHK:
                begin
                    if (st.merge_join)
                    begin
                        state_next = S_U0;
                        ret_next   = S_MUP;
                    end
                    else
                    begin
                        state_next = S_P0;
                        ret_next   = S_RESULT;
                    end
                end
                S_MUP:    state_next = S_MERGE;
                S_QANS:   state_next = S_RESULT;
                S_CNT:    state_next = st.cnt_go ? S_CNTW : S_RESULT;
                S_CNTW:   state_next = S_CNT;
                S_P0:     state_next = st.push_skip ? ret_reg : S_P1;
                S_P1:     state_next = S_P2;
                S_P2:     state_next = ret_reg;
                S_U0:     state_next = S_U1;
                S_U1:     state_next = S_U2;
                S_U2:     state_next = S_U3;
                S_U3:     state_next = S_U4;
                S_U4:     state_next = ret_reg;
                S_RESULT: state_next = S_IDLE;
                default:  state_next = S_IDLE;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    `BPA_ASSERT_NEXT(a_accept, state_reg == S_IDLE && start && !st.cfg_start, state_reg == S_DECODE, "accepted beat did not start decoding")
    `BPA_ASSERT_NEXT(a_cfg_clear, st.cfg_start, state_reg == S_CLEAR, "configuration write did not start clearing")
    `BPA_ASSERT_NEXT(a_unlink_ret, state_reg == S_U4 && !st.cfg_start, state_reg == S_SPLIT || state_reg == S_MUP, "unlink returned to a wrong state")
    `BPA_ASSERT(a_ret_point, ret_reg == S_IDLE || ret_reg == S_SPLIT || ret_reg == S_MUP || ret_reg == S_RESULT, "bad return point")

endmodule

@@ design/bpa_datapath.sv @@
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Page record and link memories, free list heads, working registers and
// result registers, driven by the controller state.
// ----------------------------------------------------------------------------
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TP_W-1:0]   cfg_wdata,
    input  logic              start,
    input  logic [1:0]        operation,
    input  logic [RANK_W-1:0] rank,
    input  logic [15:0]       page_index,
    input  state_t            cmd,
    output ctl_status_t       st,
    output logic [1:0]        status,
    output logic [PAGE_W-1:0] block_page,
    output logic [15:0]       answer,
    output logic              done
);

    // Memories.
    page_info_t        info_mem [PAGE_SLOTS];
    logic [PAGE_W-1:0] next_mem [PAGE_SLOTS];
    logic [PAGE_W-1:0] prev_mem [PAGE_SLOTS];
    page_info_t        info_rd_reg;
    logic [PAGE_W-1:0] next_rd_reg;
    logic [PAGE_W-1:0] prev_rd_reg;

    // Free list heads.
    logic              head_valid_reg [RANK_LIMIT + 1];
    logic [PAGE_W-1:0] head_idx_reg   [RANK_LIMIT + 1];

    // Control registers.
    logic [TP_W-1:0]   tp_reg;
    logic [PAGE_W-1:0] clr_reg;
    logic              done_reg;

    // Working registers.
    op_t               op_reg;
    logic [RANK_W-1:0] rank_reg, cur_reg, r_reg, p_rank_reg, ur_reg;
    logic [15:0]       page_reg, p_idx_reg, n_reg;
    logic [PAGE_W-1:0] idx_reg, cpage_reg, b_reg, u_idx_reg, nx_reg, pv_reg;
    logic              more_reg, lv_prev_reg, lv_next_reg;
    logic [1:0]        res_st_reg, status_reg;
    logic [PAGE_W-1:0] res_blk_reg, block_page_reg;
    logic [15:0]       res_ans_reg, answer_reg;

    // Port signals of memories and heads.
    logic [PAGE_W-1:0] info_raddr, next_raddr, prev_raddr;
    logic              info_we, next_we, prev_we, head_we;
    logic [PAGE_W-1:0] info_waddr, next_waddr, prev_waddr;
    page_info_t        info_wdata;
    logic [PAGE_W-1:0] next_wdata, prev_wdata;
    logic [RANK_W-1:0] head_raddr, head_waddr;
    logic              head_wvalid;
    logic [PAGE_W-1:0] head_widx;
    logic              h_valid;
    logic [PAGE_W-1:0] h_idx;

    logic [PAGE_W-1:0] buddy;
    logic [TP_W-1:0]   tp_sat;
    logic [RANK_W-1:0] top;
    logic              rank_ok, page_ok;

    assign top     = top_rank(tp_reg);
    assign tp_sat  = (cfg_wdata > TP_W'(PAGE_SLOTS)) ? TP_W'(PAGE_SLOTS) : cfg_wdata;
    assign rank_ok = (rank_reg != '0) && (rank_reg <= RANK_LIMIT_R);
    assign page_ok = page_reg < tp_reg;
    assign buddy   = cpage_reg ^ (PAGE_W'(1) << (r_reg - RANK_W'(1)));
    assign h_valid = (head_raddr <= RANK_LIMIT_R) ? head_valid_reg[head_raddr] : 1'b0;
    assign h_idx   = head_idx_reg[head_raddr];

    // Status toward the controller.
    always_comb
    begin
        st.cfg_start  = cfg_we && (cfg_wdata != '0);
        st.op         = op_reg;
        st.rank_ok    = rank_ok;
        st.page_ok    = page_ok;
        st.head_hit   = h_valid;
        st.cur_top    = (cur_reg == RANK_LIMIT_R);
        st.split_more = (cur_reg > rank_reg);
        st.taken      = info_rd_reg.taken;
        st.merge_go   = (r_reg != '0) && (r_reg < RANK_LIMIT_R)
                        && ({1'b0, buddy} < tp_reg);
        st.merge_join = !info_rd_reg.taken && (info_rd_reg.rank == r_reg);
        st.push_skip  = p_idx_reg[15] || (p_rank_reg > RANK_LIMIT_R);
        st.cnt_go     = more_reg && (n_reg != 16'(PAGE_SLOTS));
        st.clr_last   = (clr_reg == PAGE_W'(PAGE_SLOTS - 1));
    end

    // Memory and head port selection per controller state.
    always_comb
    begin
        info_raddr  = '0;
        next_raddr  = '0;
        prev_raddr  = '0;
        info_we     = 1'b0;
        info_waddr  = '0;
        info_wdata  = '0;
        next_we     = 1'b0;
        next_waddr  = '0;
        next_wdata  = '0;
        prev_we     = 1'b0;
        prev_waddr  = '0;
        prev_wdata  = '0;
        head_raddr  = cur_reg;
        head_we     = 1'b0;
        head_waddr  = '0;
        head_wvalid = 1'b0;
        head_widx   = '0;
        unique case (cmd)
            S_CLEAR:
            begin
                info_we    = 1'b1;
                info_waddr = clr_reg;
            end
            S_DECODE:
            begin
                info_raddr = page_reg[PAGE_W-1:0];
                head_raddr = rank_reg;
            end
            S_MERGE:
            begin
                info_raddr = buddy;
            end
            S_CNT:
            begin
                info_raddr = idx_reg;
                next_raddr = idx_reg;
            end
            S_TAKE:
            begin
                info_we    = 1'b1;
                info_waddr = idx_reg;
                info_wdata = '{taken: 1'b1, lv_prev: 1'b0, lv_next: 1'b0, rank: rank_reg};
            end
            S_P0:
            begin
                head_raddr = p_rank_reg;
                info_raddr = h_idx;
            end
            S_P1:
            begin
                // Link the new block in front of the current head.
                head_raddr = p_rank_reg;
                if (h_valid)
                begin
                    info_we    = 1'b1;
                    info_waddr = h_idx;
                    info_wdata = info_rd_reg;
                    info_wdata.lv_prev = 1'b1;
                    prev_we    = 1'b1;
                    prev_waddr = h_idx;
                    prev_wdata = p_idx_reg[PAGE_W-1:0];
                    next_we    = 1'b1;
                    next_waddr = p_idx_reg[PAGE_W-1:0];
                    next_wdata = h_idx;
                end
            end
            S_P2:
            begin
                head_raddr  = p_rank_reg;
                info_we     = 1'b1;
                info_waddr  = p_idx_reg[PAGE_W-1:0];
                info_wdata  = '{taken: 1'b0, lv_prev: 1'b0, lv_next: h_valid,
                                rank: p_rank_reg};
                head_we     = 1'b1;
                head_waddr  = p_rank_reg;
                head_wvalid = 1'b1;
                head_widx   = p_idx_reg[PAGE_W-1:0];
            end
            S_U0:
            begin
                info_raddr = u_idx_reg;
                next_raddr = u_idx_reg;
                prev_raddr = u_idx_reg;
            end
            S_U1:
            begin
                info_raddr = prev_rd_reg;
            end
            S_U2:
            begin
                // Bypass the block from its predecessor, or move the head.
                info_raddr = nx_reg;
                if (lv_prev_reg)
                begin
                    info_we    = 1'b1;
                    info_waddr = pv_reg;
                    info_wdata = info_rd_reg;
                    info_wdata.lv_next = lv_next_reg;
                    next_we    = 1'b1;
                    next_waddr = pv_reg;
                    next_wdata = nx_reg;
                end
                else
                begin
                    head_we     = 1'b1;
                    head_waddr  = ur_reg;
                    head_wvalid = lv_next_reg;
                    head_widx   = nx_reg;
                end
            end
            S_U3:
            begin
                if (lv_next_reg)
                begin
                    info_we    = 1'b1;
                    info_waddr = nx_reg;
                    info_wdata = info_rd_reg;
                    info_wdata.lv_prev = lv_prev_reg;
                    prev_we    = 1'b1;
                    prev_waddr = nx_reg;
                    prev_wdata = pv_reg;
                end
            end
            S_U4:
            begin
                info_we    = 1'b1;
                info_waddr = u_idx_reg;
                info_wdata = '{taken: 1'b1, lv_prev: 1'b0, lv_next: 1'b0, rank: ur_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Page record memory.
    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[info_waddr] <= info_wdata;
        end
        info_rd_reg <= info_mem[info_raddr];
    end

    // Next link memory.
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd_reg <= next_mem[next_raddr];
    end

    // Previous link memory.
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd_reg <= prev_mem[prev_raddr];
    end

    // Control state: page count, clearing sweep, head valid flags, strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg   <= TP_W'(1);
            clr_reg  <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i <= RANK_LIMIT; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= (cmd == S_RESULT);
            if (st.cfg_start)
            begin
                tp_reg  <= tp_sat;
                clr_reg <= '0;
                for (int i = 0; i <= RANK_LIMIT; i++)
                begin
                    head_valid_reg[i] <= 1'b0;
                end
            end
            else
            begin
                if (cmd == S_CLEAR)
                begin
                    clr_reg <= clr_reg + PAGE_W'(1);
                end
                if (head_we && head_waddr <= RANK_LIMIT_R)
                begin
                    head_valid_reg[head_waddr] <= head_wvalid;
                end
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (head_we && head_waddr <= RANK_LIMIT_R)
        begin
            head_idx_reg[head_waddr] <= head_widx;
        end
        unique case (cmd)
            S_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= op_t'(operation);
                    rank_reg <= rank;
                    page_reg <= page_index;
                end
            end
            S_CLEAR:
            begin
                p_idx_reg  <= '0;
                p_rank_reg <= top;
            end
            S_DECODE:
            begin
                res_st_reg  <= ST_OK;
                res_blk_reg <= '0;
                res_ans_reg <= '0;
                cur_reg     <= rank_reg;
                n_reg       <= '0;
                idx_reg     <= h_idx;
                more_reg    <= h_valid;
                if (((op_reg == OP_ALLOC || op_reg == OP_COUNT) && !rank_ok)
                    || ((op_reg == OP_FREE || op_reg == OP_QUERY) && !page_ok))
                begin
                    res_st_reg <= ST_INVALID;
                end
            end
            S_SEARCH:
            begin
                if (h_valid)
                begin
                    idx_reg   <= h_idx;
                    u_idx_reg <= h_idx;
                end
                else if (cur_reg == RANK_LIMIT_R)
                begin
                    res_st_reg <= ST_NO_SPACE;
                end
                else
                begin
                    cur_reg <= cur_reg + RANK_W'(1);
                end
            end
            S_SPLIT:
            begin
                // Push the upper half of the block one rank down.
                if (cur_reg > rank_reg)
                begin
                    cur_reg    <= cur_reg - RANK_W'(1);
                    p_rank_reg <= cur_reg - RANK_W'(1);
                    p_idx_reg  <= {1'b0, idx_reg} + (16'd1 << (cur_reg - RANK_W'(2)));
                end
            end
            S_TAKE:
            begin
                res_blk_reg <= idx_reg;
            end
            S_FCHK:
            begin
                if (!info_rd_reg.taken)
                begin
                    res_st_reg <= ST_INVALID;
                end
                r_reg     <= info_rd_reg.rank;
                cpage_reg <= page_reg[PAGE_W-1:0];
            end
            S_MERGE:
            begin
                b_reg      <= buddy;
                p_idx_reg  <= {1'b0, cpage_reg};
                p_rank_reg <= r_reg;
            end
            S_MCHK:
            begin
                u_idx_reg <= b_reg;
            end
            S_MUP:
            begin
                if (b_reg < cpage_reg)
                begin
                    cpage_reg <= b_reg;
                end
                r_reg <= r_reg + RANK_W'(1);
            end
            S_QANS:
            begin
                res_ans_reg <= 16'(info_rd_reg.taken ? info_rd_reg.rank : top);
            end
            S_CNT:
            begin
                res_ans_reg <= n_reg;
            end
            S_CNTW:
            begin
                n_reg    <= n_reg + 16'd1;
                more_reg <= info_rd_reg.lv_next;
                idx_reg  <= next_rd_reg;
            end
            S_U1:
            begin
                lv_prev_reg <= info_rd_reg.lv_prev;
                lv_next_reg <= info_rd_reg.lv_next;
                ur_reg      <= info_rd_reg.rank;
                nx_reg      <= next_rd_reg;
                pv_reg      <= prev_rd_reg;
            end
            S_RESULT:
            begin
                status_reg     <= res_st_reg;
                block_page_reg <= res_blk_reg;
                answer_reg     <= res_ans_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status     = status_reg;
    assign block_page = block_page_reg;
    assign answer     = answer_reg;
    assign done       = done_reg;

endmodule
